// ===== design/nmc_pkg.sv =====
// Shared types and constants of the nibble multichannel 1-D convolution block.
// No dependencies; imported by every design module except nmc_checker.
`timescale 1ns / 1ps

package nmc_pkg;

  localparam int TAPS        = 8;
  localparam int NIB_W       = 4;
  localparam int WORD_W      = TAPS * NIB_W;
  localparam int SUM_W       = 15;
  localparam int POS_W       = 15;
  localparam int PART_W      = 11;
  localparam int WCNT_W      = 12;
  localparam int CHCFG_W     = 5;
  localparam int WCFG_W      = 13;
  localparam int MAX_WORDS   = 4096;
  localparam int DEF_MAX_CH  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int IDX_W       = 4;

  typedef enum logic [1:0] {
    REG_COEFF    = 2'd0,
    REG_CHANNELS = 2'd1,
    REG_WORDS    = 2'd2
  } nmc_reg_t;

  // one classified request handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] cur;
    logic              last_ch;
    logic              last_wd;
    logic              has_prev;
    logic [WCNT_W-1:0] wc;
  } nmc_entry_t;

endpackage

// ===== design/nmc_front.sv =====
// Front end: accepts requests, tracks channel and word position, holds previous words.
// Depends on nmc_pkg.
`timescale 1ns / 1ps

module nmc_front import nmc_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CHCFG_W-1:0] chan_count,
  input  logic [WCFG_W-1:0]  word_count,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [WORD_W-1:0]  in_tdata,
  input  logic               q_full,
  output logic               q_push,
  output nmc_entry_t         q_entry
);

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [CW-1:0]     ch_r, ch_nxt, ch_eff, nch_m1;
  logic [WCNT_W-1:0] wc_r, wc_nxt, nwd_m1;
  logic [6:0]        cc7, m1_7;
  logic [WORD_W-1:0] prev_mem [MAX_CHANNELS];
  logic              acc, last_ch, last_wd;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;
  assign q_push    = acc;

  always_comb begin
    cc7 = {2'b00, chan_count};
    if (chan_count == '0) begin
      m1_7 = '0;
    end else if (cc7 > 7'(MAX_CHANNELS)) begin
      m1_7 = 7'(MAX_CHANNELS - 1);
    end else begin
      m1_7 = cc7 - 7'd1;
    end
    nch_m1 = CW'(m1_7);

    if (word_count == '0) begin
      nwd_m1 = '0;
    end else if (word_count > WCFG_W'(MAX_WORDS)) begin
      nwd_m1 = WCNT_W'(MAX_WORDS - 1);
    end else begin
      nwd_m1 = WCNT_W'(word_count - WCFG_W'(1));
    end

    ch_eff  = (ch_r > nch_m1) ? nch_m1 : ch_r;
    last_ch = (ch_eff >= nch_m1);
    last_wd = (wc_r >= nwd_m1);

    ch_nxt = ch_r;
    wc_nxt = wc_r;
    if (acc) begin
      if (last_ch) begin
        ch_nxt = '0;
        wc_nxt = last_wd ? '0 : wc_r + WCNT_W'(1);
      end else begin
        ch_nxt = ch_eff + CW'(1);
      end
    end
  end

  always_comb begin
    q_entry.prev     = prev_mem[ch_eff];
    q_entry.cur      = in_tdata;
    q_entry.last_ch  = last_ch;
    q_entry.last_wd  = last_wd;
    q_entry.has_prev = (wc_r != '0);
    q_entry.wc       = wc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
      wc_r <= '0;
    end else begin
      ch_r <= ch_nxt;
      wc_r <= wc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      prev_mem[ch_eff] <= in_tdata;
    end
  end

endmodule

// ===== design/nmc_queue.sv =====
// Short FIFO of classified requests between front and back.
// Depends on nmc_pkg.
`timescale 1ns / 1ps

module nmc_queue import nmc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  nmc_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output nmc_entry_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  nmc_entry_t    mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;

  assign full  = (cnt_r == NW'(QUEUE_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== design/nmc_back.sv =====
// Back end: window accumulation over channels, result bank and output register.
// Depends on nmc_pkg.
`timescale 1ns / 1ps

module nmc_back import nmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WORD_W-1:0] coeff,
  input  logic              q_valid,
  input  nmc_entry_t        q_head,
  output logic              q_pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,
  output logic              out_tlast
);

  localparam int NWIN = TAPS + 1;

  logic [SUM_W-1:0]  acc_r  [NWIN];
  logic [SUM_W-1:0]  bank_r [NWIN];
  logic [SUM_W-1:0]  sum    [NWIN];
  logic [PART_W-1:0] part   [NWIN];
  logic [2*WORD_W-1:0] smp;
  logic              busy_r, ov_r, olast_r;
  logic [IDX_W-1:0]  idx_r, end_r;
  logic [WCNT_W-1:0] bwc_r;
  logic [SUM_W-1:0]  osum_r;
  logic [POS_W-1:0]  opos_r;
  logic              ld, bank_done, bank_free, need, bank_load;

  // samples of previous word in the low half, current word above
  assign smp = {q_head.cur, q_head.prev};

  always_comb begin
    for (int a = 0; a < NWIN; a++) begin
      part[a] = '0;
      for (int k = 0; k < TAPS; k++) begin
        part[a] = part[a] + PART_W'(smp[NIB_W*(a+k) +: NIB_W] * coeff[NIB_W*k +: NIB_W]);
      end
      sum[a] = acc_r[a] + SUM_W'(part[a]);
    end
  end

  assign ld        = busy_r && (!ov_r || out_tready);
  assign bank_done = ld && (idx_r == end_r);
  assign bank_free = !busy_r || bank_done;
  assign need      = q_head.has_prev || q_head.last_wd;
  assign q_pop     = q_valid && (!(q_head.last_ch && need) || bank_free);
  assign bank_load = q_pop && q_head.last_ch && need;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NWIN; a++) begin
        acc_r[a] <= '0;
      end
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        for (int a = 0; a < NWIN; a++) begin
          acc_r[a] <= q_head.last_ch ? '0 : sum[a];
        end
      end
      if (bank_load) begin
        busy_r <= 1'b1;
      end else if (bank_done) begin
        busy_r <= 1'b0;
      end
      if (ld) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      osum_r  <= bank_r[idx_r];
      opos_r  <= {bwc_r, 3'b000} + POS_W'(idx_r) - POS_W'(TAPS);
      olast_r <= (idx_r == IDX_W'(TAPS));
    end
    if (bank_load) begin
      for (int a = 0; a < NWIN; a++) begin
        bank_r[a] <= sum[a];
      end
      idx_r <= q_head.has_prev ? '0 : IDX_W'(TAPS);
      end_r <= q_head.last_wd ? IDX_W'(TAPS) : IDX_W'(TAPS - 1);
      bwc_r <= q_head.wc;
    end else if (ld) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, opos_r, osum_r};
  assign out_tlast  = olast_r;

endmodule

// ===== design/nibble_multichannel_conv1d_top.sv =====
// Top level of the nibble multichannel 8-tap 1-D convolution: config registers, front, queue, back.
// Depends on nmc_pkg, nmc_front, nmc_queue, nmc_back.
//
//  port group | dir | payload                                  | accepted when
//  in_*       | in  | tdata[31:0] data_word                    | in_tvalid & in_tready
//  out_*      | out | tdata[14:0] sum, [29:15] pos; tlast last | out_tvalid & out_tready
//  cfg_*      | in  | cfg_index register, cfg_data value       | cfg_valid & cfg_ready
//
// One request accepted per cycle while the front queue has room.
// The last channel of a word releases 8 windows (9 on the final word, 1 for a one-word run, none for the
// first word of a longer run), sent one per cycle from the result bank while the output is not stalled.
// With the back end idle, the closing request is registered in the queue, then the bank, then the output.
// Reset is synchronous; it clears counters, accumulators, queue and output valid.
// Output stalls hold the result bank; the front keeps taking requests until the queue fills.
`timescale 1ns / 1ps

module nibble_multichannel_conv1d_top import nmc_pkg::*; #(
  parameter int MAX_CHANNELS = DEF_MAX_CH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [14:0] window_sum, [29:15] window_pos, [31:30] zero
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [WORD_W-1:0]  coeff_r;
  logic [CHCFG_W-1:0] chan_r;
  logic [WCFG_W-1:0]  words_r;
  logic               q_full, q_push, q_valid, q_pop;
  nmc_entry_t         q_in, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
      chan_r  <= CHCFG_W'(1);
      words_r <= WCFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_COEFF:    coeff_r <= cfg_data;
        REG_CHANNELS: chan_r  <= cfg_data[CHCFG_W-1:0];
        REG_WORDS:    words_r <= cfg_data[WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  nmc_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .chan_count (chan_r),
    .word_count (words_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  nmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  nmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coeff      (coeff_r),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/nmc_checker.sv =====
// Port-level checks for the convolution top level, attached by bind.
// Depends on nibble_multichannel_conv1d_top ports only.
`timescale 1ns / 1ps

module nmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // the final window sits on a word boundary
  a_last_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[17:15] == 3'b000)
    else $error("last window not word aligned");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:30] == 2'b00)
    else $error("padding bits set");

  // nothing leaves and the input is open straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result valid or input blocked after reset");

endmodule

bind nibble_multichannel_conv1d_top nmc_checker u_nmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== test/testbench.sv =====
// Self-checking testbench for nibble_multichannel_conv1d_top: a scoreboard class predicts every
// window of the multichannel 8-tap convolution, and plain tasks drive requests and register writes.
// Depends on nmc_pkg and the design sources under design/.
`timescale 1ns / 1ps

module testbench;
  import nmc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [POS_W-1:0] pos;
    logic             last;
  } window_t;

  class conv_board;
    logic [WORD_W-1:0]  coeff;
    logic [CHCFG_W-1:0] chan_cfg;
    logic [WCFG_W-1:0]  word_cfg;
    logic [WORD_W-1:0]  prev_word [DEF_MAX_CH];
    logic [SUM_W-1:0]   win_acc [TAPS+1];
    int                 chan_idx;
    int                 word_idx;
    window_t            due_windows [$];
    int                 bad_windows;

    function new();
      coeff = '0;
      chan_cfg = CHCFG_W'(1);
      word_cfg = WCFG_W'(1);
      foreach (prev_word[i]) prev_word[i] = '0;
      foreach (win_acc[i]) win_acc[i] = '0;
      chan_idx = 0;
      word_idx = 0;
      bad_windows = 0;
    endfunction

    function void set_reg(nmc_reg_t idx, logic [31:0] v);
      case (idx)
        REG_COEFF:    coeff = v;
        REG_CHANNELS: chan_cfg = v[CHCFG_W-1:0];
        REG_WORDS:    word_cfg = v[WCFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int live_channels();
      if (chan_cfg == 0) return 1;
      if (chan_cfg > DEF_MAX_CH) return DEF_MAX_CH;
      return int'(chan_cfg);
    endfunction

    function int live_words();
      if (word_cfg == 0) return 1;
      if (word_cfg > MAX_WORDS) return MAX_WORDS;
      return int'(word_cfg);
    endfunction

    // accepted data request: fold into the window sums, release windows on the last channel
    function void take_word(logic [WORD_W-1:0] w);
      int nch, nwd, ch, acc;
      logic [NIB_W-1:0]  smp [2*TAPS];
      logic [WORD_W-1:0] old;
      nch = live_channels();
      nwd = live_words();
      ch = (chan_idx >= nch) ? nch - 1 : chan_idx;
      old = prev_word[ch];
      for (int k = 0; k < TAPS; k++) begin
        smp[k] = old[NIB_W*k +: NIB_W];
        smp[k+TAPS] = w[NIB_W*k +: NIB_W];
      end
      for (int a = 0; a <= TAPS; a++) begin
        acc = int'(win_acc[a]);
        for (int k = 0; k < TAPS; k++) acc += smp[a+k] * coeff[NIB_W*k +: NIB_W];
        win_acc[a] = acc[SUM_W-1:0];
      end
      prev_word[ch] = w;
      if (ch < nch - 1) begin
        chan_idx = ch + 1;
        return;
      end
      chan_idx = 0;
      if (word_idx >= 1) begin
        for (int a = 0; a < TAPS; a++)
          due_windows.push_back('{win_acc[a], POS_W'(TAPS*(word_idx-1) + a), 1'b0});
      end
      if (word_idx >= nwd - 1) begin
        due_windows.push_back('{win_acc[TAPS], POS_W'(TAPS*word_idx), 1'b1});
        word_idx = 0;
      end else begin
        word_idx = (word_idx + 1) & (MAX_WORDS - 1);
      end
      foreach (win_acc[i]) win_acc[i] = '0;
    endfunction

    function void check_window(window_t got);
      window_t want;
      if (due_windows.size() == 0) begin
        bad_windows++;
        if (bad_windows <= 10)
          $display("unexpected window: sum=%0d pos=%0d last=%0b", got.sum, got.pos, got.last);
        return;
      end
      want = due_windows.pop_front();
      if (got !== want) begin
        bad_windows++;
        if (bad_windows <= 10)
          $display("window differs: expected sum=%0d pos=%0d last=%0b, got sum=%0d pos=%0d last=%0b",
                   want.sum, want.pos, want.last, got.sum, got.pos, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] data_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [14:0] window_sum, [29:15] window_pos
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  nmc_reg_t    cfg_index = REG_COEFF;
  logic [31:0] cfg_data = '0;

  conv_board board;
  int send_idle = 16;
  int recv_idle = 63;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  nibble_multichannel_conv1d_top dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, plus a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) board.take_word(in_tdata);
      if (out_tvalid && out_tready)
        board.check_window(window_t'({out_tdata[SUM_W-1:0], out_tdata[SUM_W +: POS_W], out_tlast}));
      if ((cfg_valid && cfg_ready) || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nibble_multichannel_conv1d_top: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(nmc_reg_t idx, logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits of the count registers carry noise
  task automatic set_config(logic [31:0] taps, int chans, int words);
    logic [31:0] pad;
    write_reg(REG_COEFF, taps);
    pad = $urandom();
    pad[CHCFG_W-1:0] = CHCFG_W'(chans);
    write_reg(REG_CHANNELS, pad);
    pad = $urandom();
    pad[WCFG_W-1:0] = WCFG_W'(words);
    write_reg(REG_WORDS, pad);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(logic [31:0] w);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // first let the last accepted request reach the scoreboard
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.due_windows.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_runs(int budget);
    int chans, words, pick, sent, n;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(9);
      chans = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(17, 31) :
              (pick == 2) ? 16 : $urandom_range(1, 4);
      pick = $urandom_range(9);
      words = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(2, 6);
      if (chans > 4) words = $urandom_range(1, 3);
      set_config(($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom(), chans, words);
      n = board.live_channels() * board.live_words();
      repeat (n) send_word(rand_word());
      sent += n;
      settle();
    end
  endtask

  initial begin
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero taps, single word
    send_word(32'hFFFF_FFFF);
    settle();
    // zero counts act as one
    set_config(32'hFFFF_FFFF, 0, 0);
    send_word(32'hFFFF_FFFF);
    settle();
    // channel count above range, all samples and taps at maximum
    set_config(32'hFFFF_FFFF, 31, 1);
    repeat (DEF_MAX_CH) send_word(32'hFFFF_FFFF);
    settle();
    // registers rewritten part way through a sequence
    set_config($urandom(), 3, 5);
    repeat (8) send_word(rand_word());
    settle();
    write_reg(REG_CHANNELS, 2);
    write_reg(REG_WORDS, 2);
    write_reg(REG_COEFF, $urandom());
    send_word(rand_word());
    settle();

    // long receiver hold-off so the block fills and stalls requests
    set_config($urandom(), 1, 6);
    hold_asks <= hold_asks + 1;
    repeat (6) send_word(rand_word());
    settle();

    // word count above range, cut short by a smaller count
    set_config($urandom(), 1, 8191);
    repeat (4) send_word(rand_word());
    settle();
    write_reg(REG_WORDS, 1);
    send_word(rand_word());
    settle();

    random_runs(70);
    send_idle = 63;
    recv_idle = 16;
    random_runs(70);
    send_idle = 0;
    recv_idle = 0;
    random_runs(70);

    repeat (16) @(posedge clk);
    if (board.bad_windows == 0 && board.due_windows.size() == 0) begin
      $display("nibble_multichannel_conv1d_top: match");
    end else begin
      $display("nibble_multichannel_conv1d_top: mismatch");
    end
    $finish;
  end

endmodule
